/* hw/rtl/two_level_page_table_manager_top_macros.svh */
// Assertion helpers shared by the page table manager modules.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef TWO_LEVEL_PAGE_TABLE_MANAGER_TOP_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_MANAGER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TLPTM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TLPTM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/tlptm_pkg.sv */
package tlptm_pkg;

   // Virtual address layout.
   localparam int INDEX_W           = 10;
   localparam int OFFSET_W          = 12;
   localparam int FRAME_W           = 20;
   localparam int ENTRIES_PER_TABLE = 1024;

   // Operation codes.
   localparam logic [1:0] OP_MAP    = 2'd0;
   localparam logic [1:0] OP_UNMAP  = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // Directory entry bits as stored.
   localparam int DIR_PRESENT_BIT = 0;
   localparam int DIR_USER_BIT    = 1;
   localparam int DIR_W           = 2;

   // Page entry flag bits.
   localparam int PTE_PRESENT_BIT = 0;
   localparam int FLAG_USER_BIT   = 2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic capture;
      logic eval;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
   } ctl_status_type;

endpackage

/* hw/rtl/tlptm_ram.sv */
module tlptm_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/tlptm_ctrl.sv */
`include "two_level_page_table_manager_top_macros.svh"

module tlptm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   output tlptm_pkg::ctl_cmd_type    cmd,
   input  tlptm_pkg::ctl_status_type status
);

   tlptm_pkg::state_type state_ff;
   tlptm_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlptm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      busy        = 1'b1;
      case (state_ff)
         tlptm_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = tlptm_pkg::ST_IDLE;
            end
         end
         tlptm_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = tlptm_pkg::ST_EVAL;
            end
         end
         tlptm_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = tlptm_pkg::ST_IDLE;
         end
         default: begin
            state_in = tlptm_pkg::ST_IDLE;
         end
      endcase
   end

   // An accepted transaction is evaluated in the very next cycle.
   `TLPTM_ASSERT_NEXT(a_accept_then_eval, start && !busy, state_ff == tlptm_pkg::ST_EVAL, "accepted transaction not evaluated")
   // After evaluation the block is free again in the next cycle.
   `TLPTM_ASSERT_NEXT(a_eval_one_cycle, state_ff == tlptm_pkg::ST_EVAL, !busy, "evaluation did not finish in one cycle")
   // The clearing pass happens only after reset.
   `TLPTM_ASSERT_NEXT(a_clear_once, state_ff != tlptm_pkg::ST_CLEAR, state_ff != tlptm_pkg::ST_CLEAR, "clearing pass re-entered")

endmodule

/* hw/rtl/tlptm_datapath.sv */
`include "two_level_page_table_manager_top_macros.svh"

module tlptm_datapath #(
   parameter int TABLES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tlptm_pkg::ctl_cmd_type     cmd,
   output tlptm_pkg::ctl_status_type  status,
   input  logic [1:0]                 req_operation,
   input  logic [31:0]                req_virt_addr,
   input  logic [31:0]                req_phys_addr,
   input  logic [11:0]                req_page_flags,
   output logic                       rsp_valid,
   output logic                       rsp_status,
   output logic                       rsp_mapped,
   output logic [31:0]                rsp_phys_result,
   output logic [31:0]                rsp_pte_value,
   output logic                       rsp_dir_present,
   output logic                       rsp_dir_user,
   output logic                       rsp_tlb_invalidate
);

   localparam int INDEX_W    = tlptm_pkg::INDEX_W;
   localparam int DIR_AW     = (TABLES > 1) ? $clog2(TABLES) : 1;
   localparam int PAGE_DEPTH = TABLES * tlptm_pkg::ENTRIES_PER_TABLE;
   localparam int PAGE_AW    = $clog2(PAGE_DEPTH);
   localparam int SLOT_W     = DIR_AW + INDEX_W;

   // Captured transaction.
   logic [1:0]  op_ff;
   logic [31:0] va_ff;
   logic [31:0] pa_ff;
   logic [11:0] fl_ff;

   // Clearing pass counter.
   logic [PAGE_AW-1:0] clear_cnt_ff;
   logic [PAGE_AW-1:0] clear_cnt_in;

   // Store ports.
   logic                       dir_we;
   logic [DIR_AW-1:0]          dir_wr_addr;
   logic [tlptm_pkg::DIR_W-1:0] dir_wr_data;
   logic [tlptm_pkg::DIR_W-1:0] dir_rd;
   logic                       page_we;
   logic [PAGE_AW-1:0]         page_wr_addr;
   logic [31:0]                page_wr_data;
   logic [31:0]                page_rd;

   // Address fields.
   logic [INDEX_W-1:0] req_di;
   logic [INDEX_W-1:0] req_pi;
   logic [SLOT_W-1:0]  req_slot;
   logic [INDEX_W-1:0] cur_di;
   logic [INDEX_W-1:0] cur_pi;
   logic [SLOT_W-1:0]  cur_slot;

   // Evaluation results.
   logic                        refused;
   logic                        dir_present_now;
   logic [tlptm_pkg::DIR_W-1:0] dir_after;
   logic                        ev_dir_we;
   logic                        ev_page_we;
   logic [31:0]                 ev_page_data;
   logic [31:0]                 pte_after;
   logic                        tlb;
   logic                        hit;

   // Result registers.
   logic        rsp_valid_ff;
   logic        rsp_status_ff;
   logic        rsp_mapped_ff;
   logic [31:0] rsp_phys_result_ff;
   logic [31:0] rsp_pte_value_ff;
   logic        rsp_dir_present_ff;
   logic        rsp_dir_user_ff;
   logic        rsp_tlb_ff;

   // Reads are addressed straight from the request ports so that the
   // entries are ready in the cycle after acceptance.
   assign req_di   = req_virt_addr[31:22];
   assign req_pi   = req_virt_addr[21:12];
   assign req_slot = {req_di[DIR_AW-1:0], req_pi};
   assign cur_di   = va_ff[31:22];
   assign cur_pi   = va_ff[21:12];
   assign cur_slot = {cur_di[DIR_AW-1:0], cur_pi};

   // Capture the transaction on acceptance.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_operation;
         va_ff <= req_virt_addr;
         pa_ff <= req_phys_addr;
         fl_ff <= req_page_flags;
      end
   end

   // Clearing pass walks every page entry once after reset.
   assign clear_cnt_in      = clear_cnt_ff + PAGE_AW'(1);
   assign status.clear_last = (clear_cnt_ff == PAGE_AW'(PAGE_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // Evaluate the operation against the entries read.
   always_comb begin
      refused         = ({1'b0, cur_di} >= (INDEX_W + 1)'(TABLES));
      dir_present_now = dir_rd[tlptm_pkg::DIR_PRESENT_BIT];
      dir_after       = dir_rd;
      ev_dir_we       = 1'b0;
      ev_page_we      = 1'b0;
      ev_page_data    = '0;
      tlb             = 1'b0;
      pte_after       = dir_present_now ? page_rd : 32'd0;
      case (op_ff)
         tlptm_pkg::OP_MAP: begin
            if (!dir_present_now) begin
               ev_dir_we = 1'b1;
               dir_after = '0;
               dir_after[tlptm_pkg::DIR_PRESENT_BIT] = 1'b1;
               dir_after[tlptm_pkg::DIR_USER_BIT]    = fl_ff[tlptm_pkg::FLAG_USER_BIT];
            end
            ev_page_we   = 1'b1;
            ev_page_data = {pa_ff[31:12], fl_ff};
            ev_page_data[tlptm_pkg::PTE_PRESENT_BIT] = 1'b1;
            pte_after    = ev_page_data;
            tlb          = 1'b1;
         end
         tlptm_pkg::OP_UNMAP: begin
            if (dir_present_now) begin
               ev_page_we = 1'b1;
               pte_after  = 32'd0;
               tlb        = 1'b1;
            end
         end
         default: begin
            // Lookup, and the unused code, change nothing.
         end
      endcase
      hit = dir_after[tlptm_pkg::DIR_PRESENT_BIT] & pte_after[tlptm_pkg::PTE_PRESENT_BIT];
   end

   // Store write ports: the clearing pass, or the evaluation cycle.
   always_comb begin
      if (cmd.clear) begin
         dir_we       = (clear_cnt_ff < PAGE_AW'(TABLES));
         dir_wr_addr  = clear_cnt_ff[DIR_AW-1:0];
         dir_wr_data  = '0;
         page_we      = 1'b1;
         page_wr_addr = clear_cnt_ff;
         page_wr_data = '0;
      end else begin
         dir_we       = cmd.eval & ev_dir_we & ~refused;
         dir_wr_addr  = cur_di[DIR_AW-1:0];
         dir_wr_data  = dir_after;
         page_we      = cmd.eval & ev_page_we & ~refused;
         page_wr_addr = cur_slot[PAGE_AW-1:0];
         page_wr_data = ev_page_data;
      end
   end

   tlptm_ram #(
      .WIDTH (tlptm_pkg::DIR_W),
      .DEPTH (TABLES)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_wr_addr),
      .wr_data (dir_wr_data),
      .rd_addr (req_di[DIR_AW-1:0]),
      .rd_data (dir_rd)
   );

   tlptm_ram #(
      .WIDTH (32),
      .DEPTH (PAGE_DEPTH)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (page_we),
      .wr_addr (page_wr_addr),
      .wr_data (page_wr_data),
      .rd_addr (req_slot[PAGE_AW-1:0]),
      .rd_data (page_rd)
   );

   // Result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.eval;
      end
   end

   // Result payload; a refused transaction reports only its status.
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         rsp_status_ff      <= refused;
         rsp_mapped_ff      <= hit & ~refused;
         rsp_phys_result_ff <= (hit && !refused) ? {pte_after[31:12], va_ff[11:0]} : 32'd0;
         rsp_pte_value_ff   <= refused ? 32'd0 : pte_after;
         rsp_dir_present_ff <= dir_after[tlptm_pkg::DIR_PRESENT_BIT] & ~refused;
         rsp_dir_user_ff    <= dir_after[tlptm_pkg::DIR_USER_BIT] & ~refused;
         rsp_tlb_ff         <= tlb & ~refused;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_mapped         = rsp_mapped_ff;
   assign rsp_phys_result    = rsp_phys_result_ff;
   assign rsp_pte_value      = rsp_pte_value_ff;
   assign rsp_dir_present    = rsp_dir_present_ff;
   assign rsp_dir_user       = rsp_dir_user_ff;
   assign rsp_tlb_invalidate = rsp_tlb_ff;

   // A result strobe lasts exactly one cycle.
   `TLPTM_ASSERT_NEXT(a_rsp_pulse, rsp_valid_ff, !rsp_valid_ff, "result strobe held for more than one cycle")
   // A refused transaction neither writes nor reports a mapping.
   `TLPTM_ASSERT_SAME(a_refused_quiet, rsp_valid_ff && rsp_status_ff, !rsp_mapped_ff && !rsp_tlb_ff && !rsp_dir_present_ff, "refused transaction reported state")
   // A mapping implies a present directory entry.
   `TLPTM_ASSERT_SAME(a_mapped_dir, rsp_valid_ff && rsp_mapped_ff, rsp_dir_present_ff, "mapped without directory entry")

endmodule

/* hw/rtl/two_level_page_table_manager_top.sv */
// Channel   Ports                                   Transaction taken when
// request   start, busy, req_*                      start high and busy low
// result    rsp_valid, rsp_*                        rsp_valid high (one cycle)
//
// For each transaction the directory and page entries are read at the
// accepting edge, and the next cycle updates both stores and loads the
// result register; a new transaction may be accepted while it is shown.
// After reset a clearing pass writes every page entry, with busy held high
// throughout.
// The receiver cannot stall; each result is presented for one cycle only.
module two_level_page_table_manager_top #(
   parameter int TABLES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_virt_addr,
   input  logic [31:0] req_phys_addr,
   input  logic [11:0] req_page_flags,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic        rsp_mapped,
   output logic [31:0] rsp_phys_result,
   output logic [31:0] rsp_pte_value,
   output logic        rsp_dir_present,
   output logic        rsp_dir_user,
   output logic        rsp_tlb_invalidate
);

   tlptm_pkg::ctl_cmd_type    cmd;
   tlptm_pkg::ctl_status_type status;

   // Sequencing.
   tlptm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // Stores and result logic.
   tlptm_datapath #(
      .TABLES (TABLES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_operation      (req_operation),
      .req_virt_addr      (req_virt_addr),
      .req_phys_addr      (req_phys_addr),
      .req_page_flags     (req_page_flags),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_mapped         (rsp_mapped),
      .rsp_phys_result    (rsp_phys_result),
      .rsp_pte_value      (rsp_pte_value),
      .rsp_dir_present    (rsp_dir_present),
      .rsp_dir_user       (rsp_dir_user),
      .rsp_tlb_invalidate (rsp_tlb_invalidate)
   );

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

// One result transaction as the block reports it.
typedef struct packed {
   logic        status;
   logic        mapped;
   logic [31:0] phys_result;
   logic [31:0] pte_value;
   logic        dir_present;
   logic        dir_user;
   logic        tlb_invalidate;
} page_walk_type;

// Shadow copy of the directory and page tables, with the walks still owed by the block.
class page_table_shadow;
   int unsigned                 tables;
   int unsigned                 failures;
   logic [tlptm_pkg::DIR_W-1:0] dir_bits[];
   logic [31:0]                 pte_store[];
   page_walk_type               owed_walks[$];

   function new(int unsigned n_tables);
      tables    = n_tables;
      failures  = 0;
      dir_bits  = new[n_tables];
      pte_store = new[n_tables * tlptm_pkg::ENTRIES_PER_TABLE];
      foreach (dir_bits[i]) dir_bits[i] = '0;
      foreach (pte_store[i]) pte_store[i] = '0;
   endfunction

   function int unsigned outstanding();
      return owed_walks.size();
   endfunction

   // Applies an accepted request transaction to the shadow tables and queues its walk.
   function void note_request(logic [1:0] op, logic [31:0] va, logic [31:0] pa,
                              logic [11:0] flags);
      int unsigned                 dir_idx;
      int unsigned                 slot;
      logic [tlptm_pkg::DIR_W-1:0] dir;
      logic [31:0]                 pte;
      page_walk_type               walk;
      walk    = '0;
      dir_idx = va[31:32-tlptm_pkg::INDEX_W];
      slot    = dir_idx * tlptm_pkg::ENTRIES_PER_TABLE
                + va[tlptm_pkg::OFFSET_W+tlptm_pkg::INDEX_W-1:tlptm_pkg::OFFSET_W];
      // An index beyond the implemented tables is refused and touches nothing.
      if (dir_idx >= tables) begin
         walk.status = 1'b1;
         owed_walks.push_back(walk);
         return;
      end
      dir = dir_bits[dir_idx];
      if (op == tlptm_pkg::OP_MAP) begin
         // The first map into a directory entry creates a fresh, cleared table.
         if (!dir[tlptm_pkg::DIR_PRESENT_BIT]) begin
            for (int i = 0; i < tlptm_pkg::ENTRIES_PER_TABLE; i++)
               pte_store[dir_idx * tlptm_pkg::ENTRIES_PER_TABLE + i] = '0;
            dir                             = '0;
            dir[tlptm_pkg::DIR_PRESENT_BIT] = 1'b1;
            dir[tlptm_pkg::DIR_USER_BIT]    = flags[tlptm_pkg::FLAG_USER_BIT];
            dir_bits[dir_idx]               = dir;
         end
         pte                             = {pa[31:tlptm_pkg::OFFSET_W], flags};
         pte[tlptm_pkg::PTE_PRESENT_BIT] = 1'b1;
         pte_store[slot]                 = pte;
         walk.tlb_invalidate             = 1'b1;
      end else if (op == tlptm_pkg::OP_UNMAP && dir[tlptm_pkg::DIR_PRESENT_BIT]) begin
         pte_store[slot]     = '0;
         walk.tlb_invalidate = 1'b1;
      end
      // The reported entries are those a lookup would see after the update.
      pte              = dir[tlptm_pkg::DIR_PRESENT_BIT] ? pte_store[slot] : '0;
      walk.pte_value   = pte;
      walk.dir_present = dir[tlptm_pkg::DIR_PRESENT_BIT];
      walk.dir_user    = dir[tlptm_pkg::DIR_USER_BIT];
      if (dir[tlptm_pkg::DIR_PRESENT_BIT] && pte[tlptm_pkg::PTE_PRESENT_BIT]) begin
         walk.mapped      = 1'b1;
         walk.phys_result = {pte[31:tlptm_pkg::OFFSET_W], va[tlptm_pkg::OFFSET_W-1:0]};
      end
      owed_walks.push_back(walk);
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endfunction

   // Compares a result transaction with the oldest walk still owed.
   function void check_response(page_walk_type got);
      page_walk_type want;
      if (owed_walks.size() == 0) begin
         $error("rsp_valid: result transaction with no request outstanding");
         failures++;
         return;
      end
      want = owed_walks.pop_front();
      compare_field("rsp_status", want.status, got.status);
      compare_field("rsp_mapped", want.mapped, got.mapped);
      compare_field("rsp_phys_result", want.phys_result, got.phys_result);
      compare_field("rsp_pte_value", want.pte_value, got.pte_value);
      compare_field("rsp_dir_present", want.dir_present, got.dir_present);
      compare_field("rsp_dir_user", want.dir_user, got.dir_user);
      compare_field("rsp_tlb_invalidate", want.tlb_invalidate, got.tlb_invalidate);
   endfunction
endclass

module tb;
   localparam int          TABLES       = 16;
   localparam int          RANDOM_ITEMS = 1830;
   localparam int          POOL_SIZE    = 32;
   localparam int          DRAIN_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   // Code 3 is not assigned; the block treats it as a lookup.
   localparam logic [1:0]  OP_SPARE     = 2'd3;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        start          = 1'b0;
   logic [1:0]  req_operation  = tlptm_pkg::OP_LOOKUP;
   logic [31:0] req_virt_addr  = '0;
   logic [31:0] req_phys_addr  = '0;
   logic [11:0] req_page_flags = '0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_status;
   logic        rsp_mapped;
   logic [31:0] rsp_phys_result;
   logic [31:0] rsp_pte_value;
   logic        rsp_dir_present;
   logic        rsp_dir_user;
   logic        rsp_tlb_invalidate;

   int unsigned      cycle_count = 0;
   logic [31:0]      page_pool[POOL_SIZE];
   page_table_shadow shadow;

   two_level_page_table_manager_top #(
      .TABLES(TABLES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_virt_addr(req_virt_addr),
      .req_phys_addr(req_phys_addr),
      .req_page_flags(req_page_flags),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_mapped(rsp_mapped),
      .rsp_phys_result(rsp_phys_result),
      .rsp_pte_value(rsp_pte_value),
      .rsp_dir_present(rsp_dir_present),
      .rsp_dir_user(rsp_dir_user),
      .rsp_tlb_invalidate(rsp_tlb_invalidate)
   );

   always #2 clock = ~clock;

   // Watchdog: the run must finish well inside the cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Monitor: note each accepted request, then check any result shown this cycle.
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (start === 1'b1 && busy === 1'b0)
            shadow.note_request(req_operation, req_virt_addr, req_phys_addr, req_page_flags);
         if (rsp_valid === 1'b1)
            shadow.check_response({rsp_status, rsp_mapped, rsp_phys_result, rsp_pte_value,
                                   rsp_dir_present, rsp_dir_user, rsp_tlb_invalidate});
      end
   end

   // Presents one request and holds it until the block takes the transaction.
   task automatic send_request(logic [1:0] op, logic [31:0] va, logic [31:0] pa,
                               logic [11:0] flags);
      start          <= 1'b1;
      req_operation  <= op;
      req_virt_addr  <= va;
      req_phys_addr  <= pa;
      req_page_flags <= flags;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Lets the clock advance first, so that the transaction just taken has been noted.
   task automatic wait_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (shadow.outstanding() != 0) @(posedge clock);
   endtask

   // A small set of pages keeps maps, unmaps and lookups landing on the same entries.
   task automatic fill_page_pool();
      foreach (page_pool[i])
         page_pool[i] = {10'($urandom_range(TABLES - 1)), 10'($urandom_range(1023)),
                         12'h000};
      page_pool[0][31:22] = '0;
      page_pool[1][31:22] = 10'(TABLES - 1);
   endtask

   initial begin
      int unsigned pick;
      logic [1:0]  op;
      logic [31:0] va;
      shadow = new(TABLES);
      fill_page_pool();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed transactions, back to back; the first is presented while the clearing pass holds busy.
      send_request(tlptm_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 12'h000);
      send_request(tlptm_pkg::OP_UNMAP,  32'h0000_1000, 32'h0000_0000, 12'h000);
      send_request(tlptm_pkg::OP_MAP,    32'h0000_0FFF, 32'hFFFF_FFFF, 12'hFFF);
      send_request(tlptm_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 12'h000);
      send_request(OP_SPARE,             32'h0000_0ABC, 32'hFFFF_FFFF, 12'hFFF);
      send_request(tlptm_pkg::OP_MAP,    32'h0000_1000, 32'h1234_5FFF, 12'h000);
      send_request(tlptm_pkg::OP_MAP,    32'h03FF_FFFF, 32'h0000_0000, 12'h002);
      send_request(tlptm_pkg::OP_LOOKUP, 32'h03FF_F000, 32'h0000_0000, 12'h000);
      send_request(tlptm_pkg::OP_MAP,    32'h03FF_E000, 32'h0000_1000, 12'h004);
      send_request(tlptm_pkg::OP_LOOKUP, 32'h03C0_0000, 32'h0000_0000, 12'h000);
      send_request(tlptm_pkg::OP_UNMAP,  32'h03FF_FFFF, 32'h0000_0000, 12'h000);
      send_request(tlptm_pkg::OP_LOOKUP, 32'h03FF_FFFF, 32'h0000_0000, 12'h000);
      send_request(tlptm_pkg::OP_UNMAP,  32'h03FF_FFFF, 32'h0000_0000, 12'h000);
      send_request(tlptm_pkg::OP_MAP,    32'h0400_0000, 32'hFFFF_F000, 12'hFFF);
      send_request(tlptm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 12'h000);
      send_request(tlptm_pkg::OP_UNMAP,  32'hFFC0_0000, 32'h0000_0000, 12'h000);
      send_request(OP_SPARE,             32'h8000_0000, 32'h0000_0000, 12'h000);
      send_request(tlptm_pkg::OP_MAP,    32'h0040_0000, 32'h8000_0000, 12'h800);
      send_request(tlptm_pkg::OP_LOOKUP, 32'h0040_0FFF, 32'h0000_0000, 12'h000);
      send_request(tlptm_pkg::OP_MAP,    32'h0000_0000, 32'h0000_0000, 12'h000);
      send_request(tlptm_pkg::OP_LOOKUP, 32'h0000_0555, 32'h0000_0000, 12'h000);
      wait_until_drained();

      // Random transactions, mostly on the page pool; a stretch runs with no gaps.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 1200) begin
            wait_until_drained();
            fill_page_pool();
         end
         if (!(n >= 700 && n < 1000) && $urandom_range(99) < 38) begin
            start <= 1'b0;
            do @(posedge clock); while ($urandom_range(99) < 38);
         end
         pick = $urandom_range(99);
         if (pick < 35)
            op = tlptm_pkg::OP_MAP;
         else if (pick < 55)
            op = tlptm_pkg::OP_UNMAP;
         else if (pick < 90)
            op = tlptm_pkg::OP_LOOKUP;
         else
            op = OP_SPARE;
         if ($urandom_range(99) < 15)
            va = $urandom();
         else
            va = page_pool[$urandom_range(POOL_SIZE - 1)] | 32'($urandom_range(4095));
         send_request(op, va, $urandom(), 12'($urandom_range(4095)));
      end
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (shadow.failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
